[rtl/core/mdio_management_frame_master_top_defines.svh]
// Assertion macros for the MDIO management master RTL.
// Included by mdiom_frame_engine, which carries the concurrent assertions; needs clk and arst_n in scope.
`ifndef MDIO_MANAGEMENT_FRAME_MASTER_TOP_DEFINES_SVH
`define MDIO_MANAGEMENT_FRAME_MASTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MDIOM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MDIOM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/mdiom_pkg.sv]
// Package for the MDIO management master: function codes, frame field codes,
// the per-period result type and the frame word builder. No dependencies.
package mdiom_pkg;

	localparam int unsigned POS_W     = 7;
	localparam int unsigned DATA_W    = 16;
	localparam int unsigned FRAME_W   = 32;
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned HDR_BITS  = 14;
	localparam int unsigned TA_BITS   = 2;

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;

	localparam logic [1:0] START_CODE = 2'b01;
	localparam logic [1:0] OP_READ    = 2'b10;
	localparam logic [1:0] OP_WRITE   = 2'b01;
	localparam logic [1:0] TA_WRITE   = 2'b10;

	typedef struct packed {
		logic              mdc_pulse;
		logic              mdio_out;
		logic              mdio_enable;
		logic              busy;
		logic              done;
		logic [DATA_W-1:0] read_value;
	} res_t;

	function automatic logic [FRAME_W-1:0] load_frame(
		input logic              is_write,
		input logic [ADDR_W-1:0] phy,
		input logic [ADDR_W-1:0] regad,
		input logic [DATA_W-1:0] data
	);
		logic [FRAME_W-1:0] word;
		word = {START_CODE, (is_write ? OP_WRITE : OP_READ), phy, regad, {(TA_BITS + DATA_W){1'b0}}};
		if (is_write) begin
			word[TA_BITS+DATA_W-1:0] = {TA_WRITE, data};
		end
		return word;
	endfunction

endpackage

[rtl/core/mdiom_frame_engine.sv]
// Frame sequencer of the MDIO management master: holds the frame state and
// works out the result of each bit period. Depends on mdiom_pkg and the defines header.
`include "mdio_management_frame_master_top_defines.svh"

module mdiom_frame_engine
	import mdiom_pkg::*;
#(
	parameter int unsigned PREAMBLE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [1:0]        func,
	input  logic [ADDR_W-1:0] phy_address,
	input  logic [ADDR_W-1:0] register_address,
	input  logic [DATA_W-1:0] write_data,
	input  logic              mdio_in,
	output res_t              res
);

	localparam logic [POS_W-1:0] PRE      = POS_W'(PREAMBLE_BITS);
	localparam logic [POS_W-1:0] HDR_END  = POS_W'(PREAMBLE_BITS + HDR_BITS);
	localparam logic [POS_W-1:0] WR_END   = POS_W'(PREAMBLE_BITS + FRAME_W);
	localparam logic [POS_W-1:0] RD_END   = POS_W'(PREAMBLE_BITS + FRAME_W - 1);

	logic [POS_W-1:0]   pos_q;
	logic               active_q;
	logic               write_q;
	logic [FRAME_W-1:0] tx_q;
	logic [DATA_W-1:0]  rx_q;

	logic               start;
	logic               act;
	logic               wr;
	logic [POS_W-1:0]   pos;
	logic [FRAME_W-1:0] tx;
	logic [DATA_W-1:0]  rx;
	logic               shift;
	logic               sample;

	always_comb begin
		start = !active_q && (func == FUNC_READ || func == FUNC_WRITE);
		act   = active_q || start;
		wr    = start ? (func == FUNC_WRITE) : write_q;
		pos   = start ? '0 : pos_q;
		tx    = start ? load_frame(func == FUNC_WRITE, phy_address, register_address, write_data)
		              : tx_q;
		rx    = start ? '0 : rx_q;

		shift  = 1'b0;
		sample = 1'b0;
		res.mdc_pulse   = 1'b0;
		res.mdio_out    = 1'b1;
		res.mdio_enable = 1'b1;
		res.busy        = 1'b0;
		res.done        = 1'b0;
		res.read_value  = '0;

		if (act) begin
			res.mdc_pulse = 1'b1;
			res.busy      = 1'b1;
			priority if (pos < PRE) begin
				res.mdio_out = 1'b1;
			end else if (pos < HDR_END || (wr && pos < WR_END)) begin
				res.mdio_out = tx[FRAME_W-1];
				shift        = 1'b1;
			end else if (!wr && pos == HDR_END) begin
				res.mdio_out    = 1'b0;
				res.mdio_enable = 1'b0;
			end else if (!wr && pos < RD_END) begin
				res.mdio_out    = 1'b0;
				res.mdio_enable = 1'b0;
				sample          = 1'b1;
			end else begin
				res.done       = 1'b1;
				res.read_value = wr ? '0 : rx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			active_q <= 1'b0;
			write_q  <= 1'b0;
			tx_q     <= '0;
			rx_q     <= '0;
		end else if (step && act) begin
			pos_q    <= pos + POS_W'(1);
			active_q <= !res.done;
			write_q  <= wr;
			tx_q     <= shift ? {tx[FRAME_W-2:0], 1'b0} : tx;
			rx_q     <= sample ? {rx[DATA_W-2:0], mdio_in} : rx;
		end
	end

	`MDIOM_ASSERT_NXT(a_done_ends_frame, step && res.done, !active_q,
		"Frame still active after its final idle period.")
	`MDIOM_ASSERT_NXT(a_read_start, step && start && func == FUNC_READ,
		active_q && !write_q && pos_q == POS_W'(1),
		"Read command did not open a read frame.")
	`MDIOM_ASSERT_IMP(a_pos_bound, active_q, pos_q <= WR_END,
		"Bit position ran past the end of the frame.")
	`MDIOM_ASSERT_IMP(a_released_low, !res.mdio_enable, !res.mdio_out && res.busy,
		"Released line outside a read turnaround or data period.")

endmodule

[rtl/core/mdiom_out_reg.sv]
// Result register of the MDIO management master: holds one period's result
// until the downstream side takes it. Depends on mdiom_pkg.
module mdiom_out_reg
	import mdiom_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	input  logic out_ready,
	output logic out_valid,
	output logic can_load,
	output res_t res_out
);

	logic valid_q;
	res_t res_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= res_in;
		end
	end

endmodule

[rtl/core/mdio_management_frame_master_top.sv]
// Clause 22 MDIO management master. Every transfer on the input channel is one
// MDC bit period and yields exactly one result, offered from the result register
// in the cycle after the input transfer and held there until it is taken; a new
// period is taken in every cycle while the result register is empty or being emptied. A read
// or write command starts a frame of
// PREAMBLE_BITS ones, start, opcode, PHY and register addresses, turnaround and
// 16 data bits, closed by an idle period that raises done_res; commands that
// arrive during a frame are ignored. The sequencer updates its frame state on each
// input transfer during a frame.
// Depends on mdiom_pkg, mdiom_frame_engine and mdiom_out_reg.
module mdio_management_frame_master_top
	import mdiom_pkg::*;
#(
	parameter int unsigned PREAMBLE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic [ADDR_W-1:0] phy_address,
	input  logic [ADDR_W-1:0] register_address,
	input  logic [DATA_W-1:0] write_data,
	input  logic              mdio_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              mdc_pulse,
	output logic              mdio_out,
	output logic              mdio_enable,
	output logic              busy_res,
	output logic              done_res,
	output logic [DATA_W-1:0] read_value
);

	logic step;
	res_t res_next;
	res_t res_cur;

	assign step = in_valid && in_ready;

	mdiom_frame_engine #(
		.PREAMBLE_BITS(PREAMBLE_BITS)
	) u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.func             (func),
		.phy_address      (phy_address),
		.register_address (register_address),
		.write_data       (write_data),
		.mdio_in          (mdio_in),
		.res              (res_next)
	);

	mdiom_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_valid),
		.res_in    (res_next),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.can_load  (in_ready),
		.res_out   (res_cur)
	);

	assign mdc_pulse   = res_cur.mdc_pulse;
	assign mdio_out    = res_cur.mdio_out;
	assign mdio_enable = res_cur.mdio_enable;
	assign busy_res    = res_cur.busy;
	assign done_res    = res_cur.done;
	assign read_value  = res_cur.read_value;

endmodule
